>>> hdl/awfe_pkg.sv
// Shared types and constants for the FIFO-replacement address table.
package awfe_pkg;

  // Table geometry
  localparam int ENTRIES = 256;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W   = $clog2(ENTRIES + 1);

  // Address halves; IPv4 keeps only the low word's low bits
  localparam int HALF_W = 64;
  localparam int V4_W   = 32;

  // Stream word widths
  localparam int S_DATA_W = 2 * HALF_W;
  localparam int S_USER_W = 3;
  localparam int M_DATA_W = 16;
  localparam int M_USER_W = 3;

  // Request modes; the unused code behaves as a lookup
  localparam logic [1:0] MODE_LOOKUP        = 2'd0;
  localparam logic [1:0] MODE_INSERT_ABSENT = 2'd1;
  localparam logic [1:0] MODE_INSERT_ALWAYS = 2'd2;

  // Address families
  localparam logic FAM_V4 = 1'b0;
  localparam logic FAM_V6 = 1'b1;

  // One stored table entry, kept normalized (IPv4 has upper bits zero)
  typedef struct packed {
    logic              fam;
    logic [HALF_W-1:0] hi;
    logic [HALF_W-1:0] lo;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

>>> hdl/awfe_ram.sv
// Generic single-write, single-read RAM with registered read data.
module awfe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> hdl/awfe_match.sv
// Entry compare unit: tests one stored entry against the search key.
module awfe_match import awfe_pkg::*; (
  input  entry_t entry,
  input  entry_t key,
  output logic   match
);

  // both sides are normalized, so family plus full 128-bit compare is exact
  always_comb begin
    match = (entry.fam == key.fam) && (entry.hi == key.hi) && (entry.lo == key.lo);
  end

endmodule

>>> hdl/address_whitelist_fifo_evict.sv
// Top level: address table with sequential scan and FIFO replacement.
//
// Bounded table of up to ENTRIES client addresses (IPv4 or IPv6). Each input
// word asks for a lookup, an insert-if-absent or an unconditional insert; one
// result word comes back per request with hit, inserted, evicted and the entry
// count after the operation. When the table is full an insert overwrites the
// oldest entry (FIFO order; lookups do not refresh age). The search reads the
// table RAM through its single read port, one entry per cycle, and stops at the
// first hit; on an empty table there is no scan at all. The input side is not
// ready while a request is in progress. The table needs no clear after reset:
// only entries below the entry count are ever read.
module address_whitelist_fifo_evict import awfe_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [S_DATA_W-1:0] s_tdata,   // addr_high [63:0], addr_low [127:64]
  input  logic [S_USER_W-1:0] s_tuser,   // mode [1:0], family [2]
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [M_DATA_W-1:0] m_tdata,   // entry_count [8:0], zero fill [15:9]
  output logic [M_USER_W-1:0] m_tuser    // hit [0], inserted [1], evicted [2]
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE
  } state_t;

  state_t           state;
  entry_t           key;
  logic [1:0]       mode_q;
  logic             hit_q;
  logic [CNT_W-1:0] scan_idx;
  logic             chk;
  logic             chk_last;
  logic [CNT_W-1:0] count;
  logic [IDX_W-1:0] oldest;

  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  entry_t           rd_entry;
  logic             match;
  logic             do_ins;
  logic             full;
  logic             out_free;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [CNT_W-1:0] count_next;

  // table storage
  awfe_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (key),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_entry)
  );

  // shared compare unit
  awfe_match u_match (
    .entry (rd_entry),
    .key   (key),
    .match (match)
  );

  // scan reads and write decision
  assign s_tready   = (state == ST_IDLE);
  assign rd_en      = (state == ST_SCAN) && !(chk && (match || chk_last));
  assign rd_addr    = scan_idx[IDX_W-1:0];
  assign do_ins     = (mode_q == MODE_INSERT_ALWAYS) ||
                      ((mode_q == MODE_INSERT_ABSENT) && !hit_q);
  assign full       = (count == CNT_W'(ENTRIES));
  assign out_free   = !m_tvalid || m_tready;
  assign wr_en      = (state == ST_DECIDE) && out_free && do_ins;
  assign wr_addr    = full ? oldest : count[IDX_W-1:0];
  assign count_next = (do_ins && !full) ? count + CNT_W'(1) : count;

  // sequencer, table bookkeeping and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      count    <= '0;
      oldest   <= '0;
      chk      <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      // drained result word, unless a new one is loaded in this cycle
      if (m_tvalid && m_tready && !((state == ST_DECIDE) && out_free)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            mode_q   <= s_tuser[1:0];
            key.fam  <= s_tuser[2];
            if (s_tuser[2] == FAM_V6) begin
              key.hi <= s_tdata[HALF_W-1:0];
              key.lo <= s_tdata[2*HALF_W-1:HALF_W];
            end else begin
              key.hi <= '0;
              key.lo <= {{(HALF_W-V4_W){1'b0}}, s_tdata[HALF_W+V4_W-1:HALF_W]};
            end
            hit_q    <= 1'b0;
            scan_idx <= '0;
            chk      <= 1'b0;
            chk_last <= 1'b0;
            state    <= (count == '0) ? ST_DECIDE : ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (chk && match) begin
            hit_q <= 1'b1;
            chk   <= 1'b0;
            state <= ST_DECIDE;
          end else if (chk && chk_last) begin
            chk   <= 1'b0;
            state <= ST_DECIDE;
          end else begin
            chk      <= 1'b1;
            chk_last <= ((scan_idx + CNT_W'(1)) == count);
            scan_idx <= scan_idx + CNT_W'(1);
          end
        end
        ST_DECIDE: begin
          if (out_free) begin
            count <= count_next;
            if (wr_en && full) begin
              oldest <= (oldest == IDX_W'(ENTRIES - 1)) ? '0 : oldest + IDX_W'(1);
            end
            m_tvalid <= 1'b1;
            m_tuser  <= {full && do_ins, do_ins, hit_q};
            m_tdata  <= {{(M_DATA_W-CNT_W){1'b0}}, count_next};
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // count stays within the table size
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(ENTRIES))
    else $error("entry count above table size");

  // the replacement pointer only moves once the table is full
  a_oldest_full: assert property (@(posedge clk) disable iff (rst)
    (oldest != '0) |-> full)
    else $error("oldest slot advanced before table filled");

  // an eviction is always an insert on a full table
  a_evict_full: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[2]) |-> (m_tuser[1] && (m_tdata[CNT_W-1:0] == CNT_W'(ENTRIES))))
    else $error("eviction reported without full insert");

  // scan never reads past the valid entries
  a_scan_range: assert property (@(posedge clk) disable iff (rst)
    rd_en |-> (scan_idx < count))
    else $error("scan read beyond valid entries");

  // an accepted request blocks the input side on the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input ready right after accept");
`endif

endmodule

>>> bench/address_whitelist_fifo_evict_checker.sv
// Scoreboard for the address table: predicts each result word and compares.
module address_whitelist_fifo_evict_checker import awfe_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  input  logic                s_tready,
  input  logic [S_DATA_W-1:0] s_tdata,   // addr_high [63:0], addr_low [127:64]
  input  logic [S_USER_W-1:0] s_tuser,   // mode [1:0], family [2]
  input  logic                m_tvalid,
  input  logic                m_tready,
  input  logic [M_DATA_W-1:0] m_tdata,   // entry_count [8:0], zero fill [15:9]
  input  logic [M_USER_W-1:0] m_tuser,   // hit [0], inserted [1], evicted [2]
  output int                  failures,
  output int                  outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic             hit;
    logic             inserted;
    logic             evicted;
    logic [CNT_W-1:0] count;
  } table_result_t;

  // Shadow copy of the table
  entry_t        shadow_table [ENTRIES];
  int            live_entries;
  int            oldest_slot;
  table_result_t pending_results [$];
  int            fail_count;

  initial begin
    failures     = 0;
    outstanding  = 0;
    fail_count   = 0;
    live_entries = 0;
    oldest_slot  = 0;
  end

  // Search, then write on an insert; the ring pointer only moves once full
  task automatic apply_request(input logic [1:0] mode, input logic fam,
                               input logic [HALF_W-1:0] hi, input logic [HALF_W-1:0] lo,
                               output table_result_t res);
    entry_t key;
    logic   found;
    logic   write;
    int     slot;
    key.fam = fam;
    key.hi  = (fam == FAM_V4) ? '0 : hi;
    key.lo  = (fam == FAM_V4) ? {{(HALF_W-V4_W){1'b0}}, lo[V4_W-1:0]} : lo;
    found = 1'b0;
    for (int i = 0; i < live_entries && !found; i++)
      if (shadow_table[i] == key) found = 1'b1;
    write = (mode == MODE_INSERT_ALWAYS) || (mode == MODE_INSERT_ABSENT && !found);
    res = '0;
    res.hit      = found;
    res.inserted = write;
    if (write) begin
      if (live_entries < ENTRIES) begin
        slot = live_entries;
        live_entries++;
      end else begin
        res.evicted = 1'b1;
        slot = oldest_slot;
        oldest_slot = (oldest_slot + 1) % ENTRIES;
      end
      shadow_table[slot] = key;
    end
    res.count = CNT_W'(live_entries);
  endtask

  // Accepted requests feed the predictor, accepted results are checked in order
  always @(posedge clk) begin : watch
    table_result_t predicted;
    table_result_t got;
    table_result_t want;
    if (rst) begin
      live_entries = 0;
      oldest_slot  = 0;
      pending_results.delete();
    end else begin
      if (s_tvalid && s_tready) begin
        apply_request(s_tuser[1:0], s_tuser[2], s_tdata[HALF_W-1:0],
                      s_tdata[2*HALF_W-1:HALF_W], predicted);
        pending_results.push_back(predicted);
      end
      if (m_tvalid && m_tready) begin
        got.hit      = m_tuser[0];
        got.inserted = m_tuser[1];
        got.evicted  = m_tuser[2];
        got.count    = m_tdata[CNT_W-1:0];
        if (pending_results.size() == 0) begin
          if (fail_count < 10)
            $display("%0t: result word with no request pending: hit=%0b ins=%0b ev=%0b cnt=%0d",
                     $realtime, got.hit, got.inserted, got.evicted, got.count);
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          if (got.hit !== want.hit || got.inserted !== want.inserted ||
              got.evicted !== want.evicted || got.count !== want.count) begin
            if (fail_count < 10)
              $display("%0t: result mismatch: expected hit=%0b ins=%0b ev=%0b cnt=%0d, got hit=%0b ins=%0b ev=%0b cnt=%0d",
                       $realtime, want.hit, want.inserted, want.evicted, want.count,
                       got.hit, got.inserted, got.evicted, got.count);
            fail_count++;
          end
        end
      end
    end
    outstanding <= pending_results.size();
    failures    <= fail_count;
  end

endmodule

>>> bench/address_whitelist_fifo_evict_tb.sv
// Stimulus and verdict for the FIFO-replacement address table.
module address_whitelist_fifo_evict_tb;
  import awfe_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] MODE_UNUSED = 2'd3;  // no meaning, acts as a lookup
  localparam int RANDOM_WORDS = 1300;
  localparam int CYCLE_LIMIT  = 2000000;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata = '0;   // addr_high [63:0], addr_low [127:64]
  logic [S_USER_W-1:0] s_tuser = '0;   // mode [1:0], family [2]
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [M_DATA_W-1:0] m_tdata;        // entry_count [8:0], zero fill [15:9]
  logic [M_USER_W-1:0] m_tuser;        // hit [0], inserted [1], evicted [2]

  int     failures;
  int     outstanding;
  int     cycle_count = 0;
  logic   steady = 1'b0;             // no idling on either side while set
  entry_t recent_addrs [$];

  address_whitelist_fifo_evict uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  address_whitelist_fifo_evict_checker checker_i (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .failures(failures), .outstanding(outstanding)
  );

  initial forever #1 clk = ~clk;

  // Run watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Result side stalls about a quarter of the time, except while steady is set
  always @(negedge clk)
    m_tready <= steady || ($urandom_range(99) >= 26);

  function automatic logic [HALF_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Offer one word, with random idle cycles ahead of it; returns at a falling edge
  task automatic send_request(input logic [1:0] mode, input logic fam,
                              input logic [HALF_W-1:0] hi, input logic [HALF_W-1:0] lo);
    if (!steady) begin
      while ($urandom_range(99) < 26) begin
        s_tvalid <= 1'b0;
        @(negedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {lo, hi};
    s_tuser  <= {fam, mode};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // Mostly reuse recent addresses so hits and evictions show up
  task automatic random_request();
    entry_t     addr;
    logic [1:0] mode;
    int         r;
    r = $urandom_range(99);
    if (r < 35) mode = MODE_LOOKUP;
    else if (r < 45) mode = MODE_UNUSED;
    else if (r < 75) mode = MODE_INSERT_ABSENT;
    else mode = MODE_INSERT_ALWAYS;
    r = $urandom_range(99);
    if (recent_addrs.size() > 0 && r < 60) begin
      addr = recent_addrs[$urandom_range(recent_addrs.size() - 1)];
      if (r < 5) addr.fam = ~addr.fam;      // same bits, other family
      if (addr.fam == FAM_V4 && $urandom_range(1)) begin
        // bits outside the IPv4 address must not matter
        addr.hi = rand64();
        addr.lo[HALF_W-1:V4_W] = $urandom;
      end
    end else begin
      addr.fam = 1'($urandom_range(1));
      addr.hi  = rand64();
      addr.lo  = rand64();
    end
    recent_addrs.push_back(addr);
    if (recent_addrs.size() > 300) void'(recent_addrs.pop_front());
    send_request(mode, addr.fam, addr.hi, addr.lo);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: empty table, masking, family split, duplicates, unused mode
    send_request(MODE_LOOKUP,        FAM_V4, '0, '0);
    send_request(MODE_INSERT_ABSENT, FAM_V4, '0, '0);
    send_request(MODE_LOOKUP,        FAM_V4, '1, 64'hFFFF_FFFF_0000_0000);
    send_request(MODE_LOOKUP,        FAM_V6, '0, '0);
    send_request(MODE_INSERT_ABSENT, FAM_V6, '1, '1);
    send_request(MODE_LOOKUP,        FAM_V6, '1, '1);
    send_request(MODE_LOOKUP,        FAM_V6, 64'h7FFF_FFFF_FFFF_FFFF, '1);
    send_request(MODE_LOOKUP,        FAM_V6, '1, 64'hFFFF_FFFF_FFFF_FFFE);
    send_request(MODE_INSERT_ABSENT, FAM_V6, '1, '1);
    send_request(MODE_INSERT_ALWAYS, FAM_V6, '1, '1);
    send_request(MODE_UNUSED,        FAM_V4, '0, '0);
    send_request(MODE_UNUSED,        FAM_V6, '0, '0);
    send_request(MODE_INSERT_ALWAYS, FAM_V4, 64'h1234_5678_9ABC_DEF0, '1);
    send_request(MODE_LOOKUP,        FAM_V4, '0, 64'h0000_0000_FFFF_FFFF);
    send_request(MODE_LOOKUP,        FAM_V6, '0, 64'h0000_0000_FFFF_FFFF);
    send_request(MODE_INSERT_ABSENT, FAM_V4, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_FFFF_FFFF);
    send_request(MODE_INSERT_ABSENT, FAM_V6, '0, 64'h0000_0000_FFFF_FFFF);
    send_request(MODE_LOOKUP,        FAM_V6, '0, 64'h0000_0000_FFFF_FFFF);
    send_request(MODE_UNUSED,        FAM_V6, '1, '1);

    // Random traffic, with one stall-free stretch and one full drain
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n == 400) steady <= 1'b1;
      if (n == 560) steady <= 1'b0;
      if (n == 700) begin
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (outstanding != 0) @(negedge clk);
      end
      random_request();
    end
    s_tvalid <= 1'b0;

    // Drain, then give the block time to show any stray result
    while (outstanding != 0) @(negedge clk);
    repeat (ENTRIES + 8) @(negedge clk);
    if (failures == 0 && outstanding == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
